// ----- hw/rtl/lbs_pkg.sv -----
package lbs_pkg;

   // one input word
   typedef struct packed {
      logic               mode;
      logic [5:0]         palette_slot;
      logic [3:0]         palette_word;
      logic signed [31:0] palette_value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [7:0]         bone_id;
      logic signed [15:0] weight;
      logic               last_influence;
   } req_word_type;

   // one result word
   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_READ,
      ST_LOAD,
      ST_MUL,
      ST_WSTART,
      ST_WMUL,
      ST_FIN,
      ST_DSTART,
      ST_DIV,
      ST_OUT
   } state_type;

   localparam logic       MODE_PALETTE    = 1'b0;
   localparam int         WORDS_PER_BONE  = 12;
   localparam logic [1:0] COL_TRANSLATION = 2'd3;
   localparam logic signed [17:0] RIGID_THRESHOLD = 18'sd16;

endpackage

// ----- hw/rtl/lbs_mul.sv -----
// Radix-2 shift-add multiplier, sign-magnitude, one multiplier bit per cycle.
module lbs_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   output logic               done,
   output logic signed [63:0] product
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] mcand_ff;
   logic [31:0] mplier_ff;
   logic [63:0] acc_ff;
   logic        neg_ff;
   logic [31:0] abs_a;
   logic [31:0] abs_b;

   assign abs_a = a[31] ? (~a + 32'd1) : a;
   assign abs_b = b[31] ? (~b + 32'd1) : b;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         mcand_ff  <= {32'd0, abs_a};
         mplier_ff <= abs_b;
         neg_ff    <= a[31] ^ b[31];
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[62:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[31:1]};
      end
   end

   assign done    = done_ff;
   assign product = neg_ff ? $signed(~acc_ff + 64'd1) : $signed(acc_ff);

endmodule

// ----- hw/rtl/lbs_div.sv -----
// Restoring divider, one quotient bit per cycle, truncates toward zero,
// saturates the quotient to 32 bits. Divisor is positive.
module lbs_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] dividend,
   input  logic [17:0]        divisor,
   output logic               done,
   output logic signed [31:0] quotient
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] dvd_ff;
   logic [63:0] q_ff;
   logic [17:0] rem_ff;
   logic [17:0] dsr_ff;
   logic        neg_ff;
   logic [18:0] rem_sh;
   logic        fits;

   assign rem_sh = {rem_ff, dvd_ff[63]};
   assign fits   = rem_sh >= {1'b0, dsr_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend[63] ? (~dividend + 64'd1) : dividend;
         neg_ff <= dividend[63];
         dsr_ff <= divisor;
         rem_ff <= '0;
         q_ff   <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[62:0], 1'b0};
         q_ff   <= {q_ff[62:0], fits};
         rem_ff <= fits ? 18'(rem_sh - {1'b0, dsr_ff}) : rem_sh[17:0];
      end
   end

   // saturate
   always_comb begin
      if (!neg_ff) begin
         quotient = (|q_ff[63:31]) ? 32'sh7FFFFFFF : $signed(q_ff[31:0]);
      end else begin
         quotient = (q_ff > 64'h80000000) ? 32'sh80000000 : $signed(32'(~q_ff + 64'd1));
      end
   end

   assign done = done_ff;

endmodule

// ----- hw/rtl/linear_blend_skinning.sv -----
// channel   direction  handshake          word
// req_      in         req_valid/stall    lbs_pkg::req_word_type
// rsp_      out        rsp_valid/stall    lbs_pkg::rsp_word_type
// csr_      in         csr_valid/ready    palette_count, 7 bits
//
// A palette word is written to the store as it is accepted. A skipped influence
// passes through PREP and FIN only; an applied one is set by the bit-serial
// multiplier, which forms 12 products. A last influence adds bit-serial
// division of the three sums unless the vertex is rigid.
// Synchronous active-high reset clears control state and the weighted-sum accumulators.
// The result register lets the block take new words while rsp_stall holds.
module linear_blend_skinning #(
   parameter int PALETTE_DEPTH  = 64,
   parameter int MAX_INFLUENCES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lbs_pkg::req_word_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lbs_pkg::rsp_word_type rsp_word,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [6:0]           csr_data
);

   localparam int ENTRIES = PALETTE_DEPTH * lbs_pkg::WORDS_PER_BONE;
   localparam int AW      = $clog2(ENTRIES);
   localparam int CW      = $clog2(MAX_INFLUENCES + 1);

   lbs_pkg::state_type state_ff, state_in;

   logic [6:0]         palette_count_ff;
   logic [CW-1:0]      count_ff;
   logic signed [17:0] total_ff;
   logic signed [17:0] applied_ff;
   logic signed [63:0] sum_ff [3];
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] res_ff [3];
   logic [7:0]         bone_ff;
   logic signed [15:0] weight_ff;
   logic               last_ff;
   logic [1:0]         row_ff;
   logic [1:0]         col_ff;
   logic signed [51:0] acc_ff;
   logic signed [31:0] rd_data_ff;
   logic               rsp_valid_ff;
   lbs_pkg::rsp_word_type rsp_word_ff;
   logic signed [31:0] mem [ENTRIES];

   logic               req_take;
   logic               out_free;
   logic               apply;
   logic               has_room;
   logic               rigid;
   logic               mem_wr;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic signed [31:0] acc_sat;

   logic               mul_start;
   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic               mul_done;
   logic signed [63:0] mul_p;
   logic               div_start;
   logic               div_done;
   logic signed [31:0] div_q;

   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign has_room  = count_ff < CW'(MAX_INFLUENCES);
   assign apply     = (weight_ff > 16'sd0) && (bone_ff < {1'b0, palette_count_ff})
                      && ({1'b0, bone_ff} < 9'(PALETTE_DEPTH));
   assign rigid     = (total_ff <= lbs_pkg::RIGID_THRESHOLD)
                      || (applied_ff <= lbs_pkg::RIGID_THRESHOLD);
   assign mem_wr    = req_take && (req_word.mode == lbs_pkg::MODE_PALETTE)
                      && (req_word.palette_word < 4'(lbs_pkg::WORDS_PER_BONE))
                      && ({3'd0, req_word.palette_slot} < 9'(PALETTE_DEPTH));
   assign wr_addr   = AW'(req_word.palette_slot) * AW'(lbs_pkg::WORDS_PER_BONE)
                      + AW'(req_word.palette_word);
   assign rd_addr   = AW'(bone_ff) * AW'(lbs_pkg::WORDS_PER_BONE) + AW'({row_ff, col_ff});
   assign acc_sat   = (acc_ff > 52'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                      (acc_ff < -52'sh80000000) ? 32'sh80000000 : acc_ff[31:0];

   // palette store
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[wr_addr] <= req_word.palette_value;
      end
      if (state_ff == lbs_pkg::ST_READ) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lbs_pkg::ST_IDLE: begin
            if (req_take && req_word.mode != lbs_pkg::MODE_PALETTE) begin
               state_in = lbs_pkg::ST_PREP;
            end
         end
         lbs_pkg::ST_PREP:   state_in = (has_room && apply) ? lbs_pkg::ST_READ : lbs_pkg::ST_FIN;
         lbs_pkg::ST_READ:   state_in = lbs_pkg::ST_LOAD;
         lbs_pkg::ST_LOAD: begin
            state_in = (col_ff == lbs_pkg::COL_TRANSLATION) ? lbs_pkg::ST_READ : lbs_pkg::ST_MUL;
         end
         lbs_pkg::ST_MUL: begin
            if (mul_done) begin
               state_in = (col_ff == 2'd2) ? lbs_pkg::ST_WSTART : lbs_pkg::ST_READ;
            end
         end
         lbs_pkg::ST_WSTART: state_in = lbs_pkg::ST_WMUL;
         lbs_pkg::ST_WMUL: begin
            if (mul_done) begin
               state_in = (row_ff == 2'd2) ? lbs_pkg::ST_FIN : lbs_pkg::ST_READ;
            end
         end
         lbs_pkg::ST_FIN: begin
            if (!last_ff) begin
               state_in = lbs_pkg::ST_IDLE;
            end else if (rigid) begin
               state_in = lbs_pkg::ST_OUT;
            end else begin
               state_in = lbs_pkg::ST_DSTART;
            end
         end
         lbs_pkg::ST_DSTART: state_in = lbs_pkg::ST_DIV;
         lbs_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = (row_ff == 2'd2) ? lbs_pkg::ST_OUT : lbs_pkg::ST_DSTART;
            end
         end
         lbs_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = lbs_pkg::ST_IDLE;
            end
         end
         default: state_in = lbs_pkg::ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_stall = 1'b1;
      mul_start = 1'b0;
      div_start = 1'b0;
      mul_a     = rd_data_ff;
      mul_b     = pos_ff[col_ff];
      unique case (state_ff)
         lbs_pkg::ST_IDLE:   req_stall = 1'b0;
         lbs_pkg::ST_LOAD:   mul_start = (col_ff != lbs_pkg::COL_TRANSLATION);
         lbs_pkg::ST_WSTART: begin
            mul_start = 1'b1;
            mul_a     = acc_sat;
            mul_b     = 32'(weight_ff);
         end
         lbs_pkg::ST_DSTART: div_start = 1'b1;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= lbs_pkg::ST_IDLE;
         palette_count_ff <= '0;
         count_ff         <= '0;
         total_ff         <= '0;
         applied_ff       <= '0;
         sum_ff[0]        <= '0;
         sum_ff[1]        <= '0;
         sum_ff[2]        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            palette_count_ff <= csr_data;
         end
         // result valid: set on a new result, cleared once taken
         if (state_ff == lbs_pkg::ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            lbs_pkg::ST_PREP: begin
               if (has_room) begin
                  count_ff <= count_ff + CW'(1);
                  total_ff <= total_ff + 18'(weight_ff);
               end
            end
            lbs_pkg::ST_WMUL: begin
               if (mul_done) begin
                  sum_ff[row_ff] <= sum_ff[row_ff] + mul_p;
                  if (row_ff == 2'd2) begin
                     applied_ff <= applied_ff + 18'(weight_ff);
                  end
               end
            end
            lbs_pkg::ST_OUT: begin
               if (out_free) begin
                  count_ff     <= '0;
                  total_ff     <= '0;
                  applied_ff   <= '0;
                  sum_ff[0]    <= '0;
                  sum_ff[1]    <= '0;
                  sum_ff[2]    <= '0;
               end
            end
            lbs_pkg::ST_FIN: begin
               if (!last_ff) begin
                  ;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         lbs_pkg::ST_IDLE: begin
            if (req_take) begin
               pos_ff[0] <= req_word.pos_x;
               pos_ff[1] <= req_word.pos_y;
               pos_ff[2] <= req_word.pos_z;
               bone_ff   <= req_word.bone_id;
               weight_ff <= req_word.weight;
               last_ff   <= req_word.last_influence;
            end
         end
         lbs_pkg::ST_PREP: begin
            row_ff <= 2'd0;
            col_ff <= lbs_pkg::COL_TRANSLATION;
         end
         lbs_pkg::ST_LOAD: begin
            if (col_ff == lbs_pkg::COL_TRANSLATION) begin
               acc_ff <= 52'(rd_data_ff);
               col_ff <= 2'd0;
            end
         end
         lbs_pkg::ST_MUL: begin
            if (mul_done) begin
               // floor to Q16.16, sign kept
               acc_ff <= acc_ff + 52'($signed(mul_p[63:16]));
               if (col_ff != 2'd2) begin
                  col_ff <= col_ff + 2'd1;
               end
            end
         end
         lbs_pkg::ST_WMUL: begin
            if (mul_done) begin
               row_ff <= row_ff + 2'd1;
               col_ff <= lbs_pkg::COL_TRANSLATION;
            end
         end
         lbs_pkg::ST_FIN: begin
            row_ff <= 2'd0;
            res_ff <= pos_ff;
         end
         lbs_pkg::ST_DIV: begin
            if (div_done) begin
               res_ff[row_ff] <= div_q;
               row_ff         <= row_ff + 2'd1;
            end
         end
         lbs_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_word_ff.out_x <= res_ff[0];
               rsp_word_ff.out_y <= res_ff[1];
               rsp_word_ff.out_z <= res_ff[2];
            end
         end
         default: ;
      endcase
   end

   lbs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   lbs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff[row_ff]),
      .divisor  (applied_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
